// ----- rtl/pol_pkg.sv -----
// Package for the positional ordered list: field widths, operation kinds,
// status codes and the command type that steers the storage cells.
// No dependencies; every other file of the block uses it.
`default_nettype none

package pol_pkg;

  // Default sizing of the list.
  localparam int CAPACITY_DEF = 16;
  localparam int ID_WIDTH_DEF = 16;

  // Fixed widths of the beat fields.
  localparam int KIND_W   = 3;
  localparam int PLACE_W  = 5;
  localparam int ENTRY_W  = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int READ_W   = 16;

  // Operation kinds carried by a request beat.
  localparam logic [KIND_W-1:0] KIND_FRONT  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND = 3'd1;
  localparam logic [KIND_W-1:0] KIND_AFTER  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

  // Status codes returned with every response beat.
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOPLACE = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  // Command broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2
  } cell_op_t;

endpackage

`default_nettype wire

// ----- rtl/pol_req_if.sv -----
// Request channel of the positional ordered list: valid/ready plus the
// operation fields. Depends on pol_pkg for the field widths.
`default_nettype none

interface pol_req_if;
  logic                       valid;
  logic                       ready;
  logic [pol_pkg::KIND_W-1:0]  kind;
  logic [pol_pkg::PLACE_W-1:0] place;
  logic [pol_pkg::ENTRY_W-1:0] entry_id;

  modport source (output valid, output kind, output place, output entry_id, input ready);
  modport sink (input valid, input kind, input place, input entry_id, output ready);
endinterface

`default_nettype wire

// ----- rtl/pol_rsp_if.sv -----
// Response channel of the positional ordered list: valid/ready plus status,
// count and read data. Depends on pol_pkg for the field widths.
`default_nettype none

interface pol_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [pol_pkg::STATUS_W-1:0] status;
  logic [pol_pkg::COUNT_W-1:0]  entry_count;
  logic [pol_pkg::READ_W-1:0]   read_id;

  modport source (output valid, output status, output entry_count, output read_id,
                  input ready);
  modport sink (input valid, input status, input entry_count, input read_id,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/pol_cell.sv -----
// One storage cell of the chain: holds one identifier; on insert it takes
// the new one or its left neighbor, on delete its right. Depends on pol_pkg.
`default_nettype none

module pol_cell #(
  parameter int ID_WIDTH = pol_pkg::ID_WIDTH_DEF,
  parameter int IDX_W    = 4,
  parameter int INDEX    = 0
) (
  input  wire logic                         clk,
  input  wire pol_pkg::cell_op_t            op,
  input  wire logic [IDX_W-1:0]             pos,
  input  wire logic [ID_WIDTH-1:0]          new_id,
  input  wire logic [ID_WIDTH-1:0]          left_data,
  input  wire logic [ID_WIDTH-1:0]          right_data,
  input  wire logic [pol_pkg::PLACE_W-1:0]  rd_idx,
  output logic      [ID_WIDTH-1:0]          data,
  output logic      [ID_WIDTH-1:0]          rd_data
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic above;
  logic at_pos;
  logic hit;

  // Place of this cell relative to the operation position.
  assign above  = MY_IDX > pos;
  assign at_pos = MY_IDX == pos;

  // Insert shifts later entries right, delete pulls them left.
  always_ff @(posedge clk) begin
    unique case (op)
      pol_pkg::CELL_INSERT: begin
        if (at_pos) begin
          data <= new_id;
        end else if (above) begin
          data <= left_data;
        end
      end
      pol_pkg::CELL_DELETE: begin
        if (at_pos || above) begin
          data <= right_data;
        end
      end
      default: begin
        data <= data;
      end
    endcase
  end

  // Read tap: this cell drives the shared bus only when it is addressed.
  assign hit     = 32'(rd_idx) == INDEX;
  assign rd_data = hit ? data : '0;

endmodule

`default_nettype wire

// ----- rtl/positional_ordered_list.sv -----
// Top level of the positional ordered list: control, count register, the
// chain of storage cells and the response register.
// Depends on pol_pkg, pol_req_if, pol_rsp_if and pol_cell.
//
// Usage:
//   Requests arrive on req (kind, place, entry_id) and each one yields exactly
//   one response beat on rsp (status, entry_count, read_id). Places count
//   from 1 at the front of the list.
//   Every cell of the chain shifts or holds in the same cycle, so an
//   operation finishes in the cycle its request beat is accepted; the
//   response is registered and appears in the next cycle. One request is taken
//   per cycle as long as the response register is empty or being drained.
//   The figure is set by the single response register: the request side is
//   ready exactly when that register can take the next result.
//   When rsp stalls, the pending response is held and req.ready drops until
//   the response beat is taken; nothing is lost or repeated.
//   Reset (rst, synchronous) empties the list and drops any pending response.
//   The request side is not ready while reset is held.
//   Cell contents are not cleared; only places within the count are read.
`default_nettype none

module positional_ordered_list #(
  parameter int CAPACITY = pol_pkg::CAPACITY_DEF,
  parameter int ID_WIDTH = pol_pkg::ID_WIDTH_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  pol_req_if.sink    req,
  pol_rsp_if.source  rsp
);

  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > pol_pkg::PLACE_W) ? CNT_W : pol_pkg::PLACE_W;
  localparam int RD_CELLS = (CAPACITY < 31) ? CAPACITY : 31;

  logic [CNT_W-1:0]            cnt;
  logic [CNT_W-1:0]            cnt_next;
  logic                        out_valid;
  pol_pkg::status_t            out_status;
  logic [pol_pkg::COUNT_W-1:0] out_count;
  logic [pol_pkg::READ_W-1:0]  out_read;

  pol_pkg::status_t            status_next;
  logic [pol_pkg::READ_W-1:0]  read_next;
  pol_pkg::cell_op_t           op;
  logic [IDX_W-1:0]            pos;
  logic [ID_WIDTH-1:0]         new_id;
  logic [ID_WIDTH-1:0]         read_bus;
  logic [pol_pkg::PLACE_W-1:0] rd_idx;
  logic                        accept;
  logic                        full;
  logic                        empty;
  logic                        place_ok;

  logic [ID_WIDTH-1:0] cell_q  [CAPACITY];
  logic [ID_WIDTH-1:0] cell_rd [CAPACITY];

  // Handshake: take a request whenever the response register can be refilled.
  assign req.ready = !rst && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  // Checks on the current count and the requested place.
  assign full     = cnt == CNT_W'(CAPACITY);
  assign empty    = cnt == '0;
  assign place_ok = (req.place != '0) && (CMP_W'(req.place) <= CMP_W'(cnt));
  assign new_id   = ID_WIDTH'(req.entry_id);
  assign rd_idx   = req.place - pol_pkg::PLACE_W'(1);

  // Decode the operation into a cell command, a status and the new count.
  always_comb begin
    op          = pol_pkg::CELL_HOLD;
    pos         = '0;
    status_next = pol_pkg::ST_DONE;
    cnt_next    = cnt;
    read_next   = '0;
    unique case (req.kind)
      pol_pkg::KIND_FRONT, pol_pkg::KIND_APPEND: begin
        if (full) begin
          status_next = pol_pkg::ST_FULL;
        end else begin
          op       = pol_pkg::CELL_INSERT;
          pos      = (req.kind == pol_pkg::KIND_FRONT) ? '0 : IDX_W'(cnt);
          cnt_next = cnt + CNT_W'(1);
        end
      end
      pol_pkg::KIND_AFTER: begin
        if (!place_ok) begin
          status_next = pol_pkg::ST_NOPLACE;
        end else if (full) begin
          status_next = pol_pkg::ST_FULL;
        end else begin
          op       = pol_pkg::CELL_INSERT;
          pos      = IDX_W'(req.place);
          cnt_next = cnt + CNT_W'(1);
        end
      end
      pol_pkg::KIND_DELETE, pol_pkg::KIND_READ: begin
        if (empty) begin
          status_next = pol_pkg::ST_EMPTY;
        end else if (!place_ok) begin
          status_next = pol_pkg::ST_NOPLACE;
        end else if (req.kind == pol_pkg::KIND_DELETE) begin
          op       = pol_pkg::CELL_DELETE;
          pos      = IDX_W'(rd_idx);
          cnt_next = cnt - CNT_W'(1);
        end else begin
          read_next = pol_pkg::READ_W'(read_bus);
        end
      end
      default: begin
        status_next = pol_pkg::ST_DONE;
      end
    endcase
    if (!accept) begin
      op = pol_pkg::CELL_HOLD;
    end
  end

  // Chain of cells; the ends see the new identifier or their own value.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ID_WIDTH-1:0] left_w;
    logic [ID_WIDTH-1:0] right_w;

    if (g == 0) begin : g_first
      assign left_w = new_id;
    end else begin : g_inner_l
      assign left_w = cell_q[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_w = cell_q[g];
    end else begin : g_inner_r
      assign right_w = cell_q[g+1];
    end

    pol_cell #(
      .ID_WIDTH (ID_WIDTH),
      .IDX_W    (IDX_W),
      .INDEX    (g)
    ) u_cell (
      .clk        (clk),
      .op         (op),
      .pos        (pos),
      .new_id     (new_id),
      .left_data  (left_w),
      .right_data (right_w),
      .rd_idx     (rd_idx),
      .data       (cell_q[g]),
      .rd_data    (cell_rd[g])
    );
  end

  // Read bus: only cells reachable by a five-bit place can be addressed.
  always_comb begin
    read_bus = '0;
    for (int i = 0; i < RD_CELLS; i++) begin
      read_bus = read_bus | cell_rd[i];
    end
  end

  // Count register and response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        cnt       <= cnt_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status <= status_next;
      out_count  <= pol_pkg::COUNT_W'(cnt_next);
      out_read   <= read_next;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.entry_count = out_count;
  assign rsp.read_id     = out_read;

  // The count never grows past the capacity.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(CAPACITY))
    else $error("list count exceeds capacity");

  // A failed operation leaves the count as it was.
  a_fail_keeps: assert property (@(posedge clk) disable iff (rst)
    accept && (status_next != pol_pkg::ST_DONE) |=> cnt == $past(cnt))
    else $error("count changed on a failed operation");

  // Every accepted request shows a response in the next cycle.
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted request produced no response");

  // The reported count matches the count register.
  a_count_match: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_count == pol_pkg::COUNT_W'(cnt))
    else $error("reported count differs from held count");

endmodule

`default_nettype wire

// ----- tb/tb_positional_ordered_list.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the positional ordered list: a directed table,
// then random operation sequences checked against an in-bench list predictor.
// Depends on pol_pkg, pol_req_if, pol_rsp_if and positional_ordered_list.

module tb_positional_ordered_list;
  import pol_pkg::*;

  localparam int LIST_CAP      = CAPACITY_DEF;
  localparam int RANDOM_ITEMS  = 700;
  localparam int HOLD_CYCLES   = 80;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int REPORT_LIMIT  = 10;
  localparam int DIR_ROWS      = 26;

  // Kinds that the block ignores.
  localparam logic [KIND_W-1:0] KIND_SPARE_5 = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

  typedef struct packed {
    status_t              status;
    logic [COUNT_W-1:0]   count;
    logic [READ_W-1:0]    rd;
  } list_result_t;

  // One row of the directed table; the expected beat is used only when typed.
  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [PLACE_W-1:0] place;
    logic [ENTRY_W-1:0] id;
    int                 reps;
    bit                 typed;
    status_t            status;
    logic [COUNT_W-1:0] count;
    logic [READ_W-1:0]  rd;
  } list_step_t;

  logic clk = 1'b0;
  logic rst;

  pol_req_if req_ch ();
  pol_rsp_if rsp_ch ();

  positional_ordered_list dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Predicted list contents and length.
  logic [ENTRY_W-1:0] list_ids [LIST_CAP];
  int                 list_len;

  list_result_t pending_results [$];
  int           fail_count;

  // Flags from the sender that steer the receiver.
  bit hold_go;
  bit calm;

  list_step_t dir_steps [DIR_ROWS] = '{
    '{KIND_READ,    5'd1,  16'h0000, 1,  1'b1, ST_EMPTY,   5'd0,  16'h0},
    '{KIND_DELETE,  5'd0,  16'h0000, 1,  1'b1, ST_EMPTY,   5'd0,  16'h0},
    '{KIND_AFTER,   5'd0,  16'hC3C3, 1,  1'b1, ST_NOPLACE, 5'd0,  16'h0},
    '{KIND_FRONT,   5'd0,  16'hFFFF, 1,  1'b1, ST_DONE,    5'd1,  16'h0},
    '{KIND_APPEND,  5'd31, 16'h0000, 1,  1'b1, ST_DONE,    5'd2,  16'h0},
    '{KIND_AFTER,   5'd1,  16'h1234, 1,  1'b1, ST_DONE,    5'd3,  16'h0},
    '{KIND_READ,    5'd0,  16'h0000, 1,  1'b1, ST_NOPLACE, 5'd3,  16'h0},
    '{KIND_READ,    5'd31, 16'hFFFF, 1,  1'b1, ST_NOPLACE, 5'd3,  16'h0},
    '{KIND_READ,    5'd2,  16'h0000, 1,  1'b0, ST_DONE,    5'd0,  16'h0},
    '{KIND_SPARE_5, 5'd2,  16'hBEEF, 1,  1'b1, ST_DONE,    5'd3,  16'h0},
    '{KIND_SPARE_6, 5'd0,  16'h5555, 1,  1'b1, ST_DONE,    5'd3,  16'h0},
    '{KIND_SPARE_7, 5'd31, 16'hAAAA, 1,  1'b1, ST_DONE,    5'd3,  16'h0},
    '{KIND_DELETE,  5'd3,  16'h0000, 1,  1'b1, ST_DONE,    5'd2,  16'h0},
    '{KIND_AFTER,   5'd3,  16'h4321, 1,  1'b1, ST_NOPLACE, 5'd2,  16'h0},
    '{KIND_APPEND,  5'd0,  16'h8000, 14, 1'b0, ST_DONE,    5'd0,  16'h0},
    '{KIND_FRONT,   5'd0,  16'h0F0F, 1,  1'b1, ST_FULL,    5'd16, 16'h0},
    '{KIND_APPEND,  5'd0,  16'hF0F0, 1,  1'b1, ST_FULL,    5'd16, 16'h0},
    '{KIND_AFTER,   5'd16, 16'h3C3C, 1,  1'b1, ST_FULL,    5'd16, 16'h0},
    '{KIND_AFTER,   5'd17, 16'h3C3C, 1,  1'b1, ST_NOPLACE, 5'd16, 16'h0},
    '{KIND_READ,    5'd16, 16'h0000, 1,  1'b0, ST_DONE,    5'd0,  16'h0},
    '{KIND_READ,    5'd1,  16'h0000, 1,  1'b0, ST_DONE,    5'd0,  16'h0},
    '{KIND_DELETE,  5'd16, 16'h0000, 1,  1'b1, ST_DONE,    5'd15, 16'h0},
    '{KIND_DELETE,  5'd1,  16'h0000, 1,  1'b1, ST_DONE,    5'd14, 16'h0},
    '{KIND_AFTER,   5'd14, 16'h7FFF, 1,  1'b1, ST_DONE,    5'd15, 16'h0},
    '{KIND_DELETE,  5'd1,  16'h0000, 15, 1'b0, ST_DONE,    5'd0,  16'h0},
    '{KIND_READ,    5'd1,  16'h0000, 1,  1'b1, ST_EMPTY,   5'd0,  16'h0}
  };

  // Clock: 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Apply one operation to the predicted list and return the expected beat.
  function automatic list_result_t list_apply(input logic [KIND_W-1:0] kind,
                                              input logic [PLACE_W-1:0] place,
                                              input logic [ENTRY_W-1:0] id);
    list_result_t res;
    bit           place_ok;
    bit           do_insert;
    int           ins_pos;
    res.status = ST_DONE;
    res.rd = '0;
    do_insert = 1'b0;
    ins_pos = 0;
    place_ok = (place >= 1) && (int'(place) <= list_len);
    case (kind)
      KIND_FRONT, KIND_APPEND: begin
        if (list_len >= LIST_CAP) begin
          res.status = ST_FULL;
        end else begin
          do_insert = 1'b1;
          ins_pos = (kind == KIND_FRONT) ? 0 : list_len;
        end
      end
      KIND_AFTER: begin
        if (!place_ok) begin
          res.status = ST_NOPLACE;
        end else if (list_len >= LIST_CAP) begin
          res.status = ST_FULL;
        end else begin
          do_insert = 1'b1;
          ins_pos = int'(place);
        end
      end
      KIND_DELETE, KIND_READ: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else if (!place_ok) begin
          res.status = ST_NOPLACE;
        end else if (kind == KIND_DELETE) begin
          for (int i = int'(place) - 1; i + 1 < list_len; i++) list_ids[i] = list_ids[i + 1];
          list_len--;
        end else begin
          res.rd = list_ids[int'(place) - 1];
        end
      end
      default: ;
    endcase
    // Open a gap at the insert position and shift the tail back by one.
    if (do_insert) begin
      for (int i = list_len; i > ins_pos; i--) list_ids[i] = list_ids[i - 1];
      list_ids[ins_pos] = id;
      list_len++;
    end
    res.count = COUNT_W'(list_len);
    return res;
  endfunction

  // Offer one request beat, wait for acceptance, record the expected result,
  // then maybe leave a gap before the next beat.
  task automatic offer_op(input logic [KIND_W-1:0] kind, input logic [PLACE_W-1:0] place,
                          input logic [ENTRY_W-1:0] id, input bit typed,
                          input list_result_t typed_res);
    list_result_t res;
    req_ch.valid <= 1'b1;
    req_ch.kind <= kind;
    req_ch.place <= place;
    req_ch.entry_id <= id;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    res = list_apply(kind, place, id);
    pending_results.push_back(typed ? typed_res : res);
    if (!calm && $urandom_range(99) < 30) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Sender: reset, directed table, random sequences, drain and verdict.
  initial begin
    list_result_t       typed_res;
    logic [KIND_W-1:0]  kind;
    logic [PLACE_W-1:0] place;
    logic [ENTRY_W-1:0] id;
    int                 roll;
    int                 ins_pct;
    int                 del_pct;
    int                 guard;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.kind <= '0;
    req_ch.place <= '0;
    req_ch.entry_id <= '0;
    hold_go <= 1'b0;
    calm <= 1'b0;
    list_len = 0;
    fail_count = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table; repeated rows step the identifier.
    for (int s = 0; s < DIR_ROWS; s++) begin
      for (int r = 0; r < dir_steps[s].reps; r++) begin
        typed_res.status = dir_steps[s].status;
        typed_res.count = dir_steps[s].count;
        typed_res.rd = dir_steps[s].rd;
        offer_op(dir_steps[s].kind, dir_steps[s].place, dir_steps[s].id + ENTRY_W'(r),
                 dir_steps[s].typed, typed_res);
      end
    end

    // Random sequences, alternating between growing, shrinking and mixed phases.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 150) hold_go <= 1'b1;
      if (n == 300) calm <= 1'b1;
      if (n == 420) calm <= 1'b0;
      case ((n / 60) % 3)
        0: begin ins_pct = 70; del_pct = 15; end
        1: begin ins_pct = 15; del_pct = 70; end
        default: begin ins_pct = 40; del_pct = 30; end
      endcase
      id = ENTRY_W'($urandom);
      if ($urandom_range(99) < 10) begin
        // Noise: any kind, any place.
        kind = KIND_W'($urandom);
        place = PLACE_W'($urandom);
      end else begin
        roll = $urandom_range(99);
        if (roll < ins_pct) begin
          case ($urandom_range(2))
            0: kind = KIND_FRONT;
            1: kind = KIND_APPEND;
            default: kind = KIND_AFTER;
          endcase
        end else if (roll < ins_pct + del_pct) begin
          kind = KIND_DELETE;
        end else begin
          kind = KIND_READ;
        end
        // Mostly a place inside the list, sometimes zero, one past the end or any value.
        if (list_len > 0 && $urandom_range(99) < 85) begin
          place = PLACE_W'($urandom_range(1, list_len));
        end else begin
          case ($urandom_range(2))
            0: place = '0;
            1: place = PLACE_W'(list_len + 1);
            default: place = PLACE_W'($urandom);
          endcase
        end
      end
      offer_op(kind, place, id, 1'b0, typed_res);
    end
    req_ch.valid <= 1'b0;

    // Drain outstanding results, then wait for any stray beats before the verdict.
    guard = 0;
    while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (pending_results.size() != 0) begin
      $display("%0d expected results never arrived", pending_results.size());
      fail_count++;
    end
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Receiver: random back-pressure, one long hold-off, and a stall-free stretch.
  initial begin
    bit hold_served;
    hold_served = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_served) begin
        hold_served = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      rsp_ch.ready <= calm || ($urandom_range(99) >= 30);
    end
  end

  // Compare every accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    list_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("Unexpected result beat: status %0d count %0d read %h",
                   rsp_ch.status, rsp_ch.entry_count, rsp_ch.read_id);
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.status !== want.status || rsp_ch.entry_count !== want.count ||
            rsp_ch.read_id !== want.rd) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("Result mismatch: expected status %0d count %0d read %h, got %0d %0d %h",
                     want.status, want.count, want.rd,
                     rsp_ch.status, rsp_ch.entry_count, rsp_ch.read_id);
        end
      end
    end
  end

  // Overall time limit.
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/pol_pkg.sv
rtl/pol_req_if.sv
rtl/pol_rsp_if.sv
rtl/pol_cell.sv
rtl/positional_ordered_list.sv
tb/tb_positional_ordered_list.sv
